// ----- design/mbsp_pkg.sv -----
package mbsp_pkg;

    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_NOTE_ON  = 4'd1;
    localparam logic [3:0] EV_NOTE_OFF = 4'd2;
    localparam logic [3:0] EV_CC       = 4'd3;
    localparam logic [3:0] EV_PROGRAM  = 4'd4;
    localparam logic [3:0] EV_CLOCK    = 4'd5;
    localparam logic [3:0] EV_START    = 4'd6;
    localparam logic [3:0] EV_CONTINUE = 4'd7;
    localparam logic [3:0] EV_STOP     = 4'd8;

    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    localparam logic [3:0] TY_NOTE_OFF = 4'h8;
    localparam logic [3:0] TY_NOTE_ON  = 4'h9;
    localparam logic [3:0] TY_CC       = 4'hB;
    localparam logic [3:0] TY_PROGRAM  = 4'hC;
    localparam logic [3:0] TY_PRESSURE = 4'hD;
    localparam logic [3:0] TY_SYSTEM   = 4'hF;

    localparam logic [1:0] POS_IDLE   = 2'd0;
    localparam logic [1:0] POS_STATUS = 2'd1;
    localparam logic [1:0] POS_FIRST  = 2'd2;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] last_status;
        logic [6:0] pending_data;
        logic [1:0] byte_position;
    } t_state;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [3:0] channel;
        logic [6:0] key_or_number;
        logic [6:0] amount;
        logic [1:0] raw_length;
        logic [7:0] raw_first;
        logic [6:0] raw_second;
        logic [6:0] raw_third;
    } t_result;

endpackage

// ----- design/mbsp_decode.sv -----
module mbsp_decode
    import mbsp_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_state     i_state,
    output t_state     o_next_state,
    output logic       o_emit,
    output t_result    o_result
);

    logic [3:0] status_type;
    logic [3:0] status_chan;
    logic [6:0] data;
    logic [1:0] pos_eff;

    assign status_type = i_state.last_status[7:4];
    assign status_chan = i_state.last_status[3:0];
    assign data        = i_byte[6:0];

    always_comb begin
        o_next_state = i_state;
        o_emit       = 1'b0;
        o_result     = '0;
        pos_eff      = i_state.byte_position;

        if (i_byte[7]) begin
            case (i_byte)
                ST_CLOCK:    o_result.event_kind = EV_CLOCK;
                ST_START:    o_result.event_kind = EV_START;
                ST_CONTINUE: o_result.event_kind = EV_CONTINUE;
                ST_STOP:     o_result.event_kind = EV_STOP;
                default:     o_result.event_kind = EV_NONE;
            endcase
            o_next_state.last_status   = i_byte;
            o_next_state.byte_position = POS_STATUS;
            o_emit                     = 1'b1;
            o_result.raw_length        = LEN_ONE;
            o_result.raw_first         = i_byte;
        end else begin
            if (!(i_state.byte_position inside {POS_STATUS, POS_FIRST})) begin
                pos_eff = (status_type == TY_SYSTEM) ? POS_IDLE : POS_STATUS;
            end
            case (pos_eff)
                POS_STATUS: begin
                    if (status_type == TY_PROGRAM) begin
                        o_next_state.byte_position = POS_IDLE;
                        o_emit                 = 1'b1;
                        o_result.event_kind    = EV_PROGRAM;
                        o_result.channel       = status_chan;
                        o_result.key_or_number = data;
                        o_result.raw_length    = LEN_TWO;
                        o_result.raw_first     = i_state.last_status;
                        o_result.raw_second    = data;
                    end else if (status_type == TY_PRESSURE) begin
                        o_next_state.byte_position = POS_IDLE;
                        o_emit              = 1'b1;
                        o_result.raw_length = LEN_TWO;
                        o_result.raw_first  = i_state.last_status;
                        o_result.raw_second = data;
                    end else begin
                        o_next_state.pending_data  = data;
                        o_next_state.byte_position = POS_FIRST;
                    end
                end
                POS_FIRST: begin
                    o_next_state.byte_position = POS_IDLE;
                    o_emit              = 1'b1;
                    o_result.raw_length = LEN_THREE;
                    o_result.raw_first  = i_state.last_status;
                    o_result.raw_second = i_state.pending_data;
                    o_result.raw_third  = data;
                    case (status_type)
                        TY_NOTE_OFF, TY_NOTE_ON, TY_CC: begin
                            o_result.channel       = status_chan;
                            o_result.key_or_number = i_state.pending_data;
                            o_result.amount        = data;
                            if (status_type == TY_CC) begin
                                o_result.event_kind = EV_CC;
                            end else if (status_type == TY_NOTE_ON && data != 7'd0) begin
                                o_result.event_kind = EV_NOTE_ON;
                            end else begin
                                o_result.event_kind = EV_NOTE_OFF;
                            end
                        end
                        default: o_result.event_kind = EV_NONE;
                    endcase
                end
                default: begin
                    // data after a system status with nothing pending is dropped
                    o_emit = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- design/mbsp_out_reg.sv -----
module mbsp_out_reg
    import mbsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/midi_byte_stream_parser.sv -----
// channel  | direction | signals
// input    | in        | i_valid, o_stall, i_midi_byte
// result   | out       | o_valid, i_stall, o_event_kind .. o_raw_third
//
// one byte per cycle sustained while the result register is not full and stalled; a beat
// passes from acceptance through the input register, then decode into the result register
// reset clears the stored status, pending data byte and position to zero
// o_stall rises only when the input register holds a byte that produces a
// result while the result register is full and stalled
module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_midi_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_event_kind,
    output logic [3:0] o_channel,
    output logic [6:0] o_key_or_number,
    output logic [6:0] o_amount,
    output logic [1:0] o_raw_length,
    output logic [7:0] o_raw_first,
    output logic [6:0] o_raw_second,
    output logic [6:0] o_raw_third
);

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    logic       emit;
    t_result    result;
    t_result    out_result;
    logic       can_load;
    logic       advance;
    logic       accept;

    mbsp_decode u_decode (
        .i_byte       (r_in_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_emit       (emit),
        .o_result     (result)
    );

    assign advance = r_in_valid && (!emit || can_load);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_midi_byte;
        end
    end

    mbsp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && emit),
        .i_result   (result),
        .i_stall    (i_stall),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_result   (out_result)
    );

    assign o_event_kind    = out_result.event_kind;
    assign o_channel       = out_result.channel;
    assign o_key_or_number = out_result.key_or_number;
    assign o_amount        = out_result.amount;
    assign o_raw_length    = out_result.raw_length;
    assign o_raw_first     = out_result.raw_first;
    assign o_raw_second    = out_result.raw_second;
    assign o_raw_third     = out_result.raw_third;

`ifndef SYNTH
    a_pos_never_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.byte_position != 2'd3)
        else $error("byte position reached unused code");

    a_status_sets_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte[7]) |=> (r_state.byte_position == POS_STATUS))
        else $error("status beat did not restart assembly");

    a_note_on_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == EV_NOTE_ON) |->
            (o_raw_length == LEN_THREE && o_amount != 7'd0))
        else $error("note on with bad length or zero velocity");

    a_realtime_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_kind == EV_CLOCK || o_event_kind == EV_START ||
                     o_event_kind == EV_CONTINUE || o_event_kind == EV_STOP)) |->
            (o_raw_length == LEN_ONE && o_raw_first[7]))
        else $error("realtime event not a single status beat");

    a_raw_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_raw_length != 2'd0))
        else $error("result beat with zero raw length");
`endif

endmodule

// ----- tb/sv/midi_byte_stream_parser_test.sv -----
module midi_byte_stream_parser_test
    import mbsp_pkg::*;
();

    typedef struct {
        logic [7:0] midi;
        bit         fixed;
        t_result    want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_midi_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [3:0] o_event_kind;
    logic [3:0] o_channel;
    logic [6:0] o_key_or_number;
    logic [6:0] o_amount;
    logic [1:0] o_raw_length;
    logic [7:0] o_raw_first;
    logic [6:0] o_raw_second;
    logic [6:0] o_raw_third;

    // running copy of the parser state
    logic [7:0] run_status = 8'h00;
    logic [6:0] held_data = 7'h00;
    logic [1:0] run_pos = POS_IDLE;

    t_result expected_msgs[$];
    logic [7:0] midi_stream[$];
    t_row directed_rows[$];
    t_result head_msg;
    int fail_count = 0;
    int bytes_sent = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    midi_byte_stream_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_midi_byte    (i_midi_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_channel      (o_channel),
        .o_key_or_number(o_key_or_number),
        .o_amount       (o_amount),
        .o_raw_length   (o_raw_length),
        .o_raw_first    (o_raw_first),
        .o_raw_second   (o_raw_second),
        .o_raw_third    (o_raw_third)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [3:0] ty;
        logic [3:0] ch;
        ty = run_status[7:4];
        ch = run_status[3:0];
        r = '0;
        if (b[7]) begin
            case (b)
                ST_CLOCK:    r.event_kind = EV_CLOCK;
                ST_START:    r.event_kind = EV_START;
                ST_CONTINUE: r.event_kind = EV_CONTINUE;
                ST_STOP:     r.event_kind = EV_STOP;
                default:     r.event_kind = EV_NONE;
            endcase
            run_status = b;
            run_pos = POS_STATUS;
            r.raw_length = LEN_ONE;
            r.raw_first = b;
            return 1'b1;
        end
        if (run_pos != POS_STATUS && run_pos != POS_FIRST) begin
            if (ty == TY_SYSTEM) begin
                return 1'b0;
            end
            run_pos = POS_STATUS;
        end
        if (run_pos == POS_STATUS) begin
            if (ty == TY_PROGRAM || ty == TY_PRESSURE) begin
                run_pos = POS_IDLE;
                if (ty == TY_PROGRAM) begin
                    r.event_kind = EV_PROGRAM;
                    r.channel = ch;
                    r.key_or_number = b[6:0];
                end
                r.raw_length = LEN_TWO;
                r.raw_first = run_status;
                r.raw_second = b[6:0];
                return 1'b1;
            end
            held_data = b[6:0];
            run_pos = POS_FIRST;
            return 1'b0;
        end
        run_pos = POS_IDLE;
        r.raw_length = LEN_THREE;
        r.raw_first = run_status;
        r.raw_second = held_data;
        r.raw_third = b[6:0];
        if (ty == TY_NOTE_OFF || ty == TY_NOTE_ON || ty == TY_CC) begin
            if (ty == TY_CC) begin
                r.event_kind = EV_CC;
            end else if (ty == TY_NOTE_ON && b[6:0] != 7'd0) begin
                r.event_kind = EV_NOTE_ON;
            end else begin
                r.event_kind = EV_NOTE_OFF;
            end
            r.channel = ch;
            r.key_or_number = held_data;
            r.amount = b[6:0];
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // check each result beat against the oldest expected message
    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_msgs.size() == 0) begin
                report_mismatch("result beat with no message expected");
            end else begin
                head_msg = expected_msgs.pop_front();
                check_field("event_kind", 8'(o_event_kind), 8'(head_msg.event_kind));
                check_field("channel", 8'(o_channel), 8'(head_msg.channel));
                check_field("key_or_number", 8'(o_key_or_number),
                            8'(head_msg.key_or_number));
                check_field("amount", 8'(o_amount), 8'(head_msg.amount));
                check_field("raw_length", 8'(o_raw_length), 8'(head_msg.raw_length));
                check_field("raw_first", o_raw_first, head_msg.raw_first);
                check_field("raw_second", 8'(o_raw_second), 8'(head_msg.raw_second));
                check_field("raw_third", 8'(o_raw_third), 8'(head_msg.raw_third));
            end
            stall_left = calm ? 0 : $urandom_range(0, 17);
        end else if (stall_left != 0) begin
            stall_left--;
        end
        i_stall <= (stall_left != 0);
    end

    task automatic send_byte(input logic [7:0] b, input bit fixed, input t_result want);
        int gap;
        t_result r;
        bit has_msg;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_midi_byte <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        has_msg = parse_byte(b, r);
        if (fixed) begin
            expected_msgs.push_back(want);
        end else if (has_msg) begin
            expected_msgs.push_back(r);
        end
        bytes_sent++;
    endtask

    task automatic add_row(input logic [7:0] b, input bit fixed, input logic [3:0] kind,
                           input logic [1:0] len, input logic [7:0] first,
                           input logic [6:0] third);
        t_row row;
        row.midi = b;
        row.fixed = fixed;
        row.want = '0;
        row.want.event_kind = kind;
        row.want.raw_length = len;
        row.want.raw_first = first;
        row.want.raw_third = third;
        directed_rows.push_back(row);
    endtask

    function automatic logic [7:0] data_byte();
        logic [6:0] v;
        case ($urandom_range(0, 5))
            0:       v = 7'h00;
            1:       v = 7'h7F;
            default: v = 7'($urandom);
        endcase
        return {1'b0, v};
    endfunction

    function automatic logic [7:0] realtime_byte();
        case ($urandom_range(0, 3))
            0:       return ST_CLOCK;
            1:       return ST_START;
            2:       return ST_CONTINUE;
            default: return ST_STOP;
        endcase
    endfunction

    function automatic logic [7:0] channel_status();
        logic [2:0] ty;
        logic [3:0] ch;
        ty = 3'($urandom_range(0, 6));
        ch = 4'($urandom);
        return {1'b1, ty, ch};
    endfunction

    task automatic plan_burst();
        logic [7:0] st;
        logic [3:0] low;
        int n;
        calm = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
            5: begin
                repeat ($urandom_range(1, 3)) midi_stream.push_back(data_byte());
            end
            6: begin
                midi_stream.push_back(realtime_byte());
            end
            7: begin
                low = 4'($urandom);
                midi_stream.push_back({TY_SYSTEM, low});
                repeat ($urandom_range(0, 3)) midi_stream.push_back(data_byte());
            end
            8: begin
                midi_stream.push_back(channel_status());
                midi_stream.push_back(data_byte());
                midi_stream.push_back(8'h80 | 8'($urandom));
            end
            9: begin
                repeat ($urandom_range(1, 4)) midi_stream.push_back(8'($urandom));
            end
            default: begin
                st = channel_status();
                midi_stream.push_back(st);
                n = $urandom_range(1, 4);
                repeat (n) begin
                    midi_stream.push_back(data_byte());
                    if (st[7:4] != TY_PROGRAM && st[7:4] != TY_PRESSURE) begin
                        midi_stream.push_back(data_byte());
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        midi_stream.push_back(realtime_byte());
                    end
                end
            end
        endcase
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // data before any status, then system status handling
        add_row(8'h00, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h7F, 1'b1, EV_NONE, LEN_THREE, 8'h00, 7'h7F);
        add_row(ST_CLOCK, 1'b1, EV_CLOCK, LEN_ONE, ST_CLOCK, 7'h00);
        add_row(8'h05, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h06, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h07, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(ST_START, 1'b1, EV_START, LEN_ONE, ST_START, 7'h00);
        add_row(ST_CONTINUE, 1'b1, EV_CONTINUE, LEN_ONE, ST_CONTINUE, 7'h00);
        add_row(ST_STOP, 1'b1, EV_STOP, LEN_ONE, ST_STOP, 7'h00);
        add_row(8'hFF, 1'b1, EV_NONE, LEN_ONE, 8'hFF, 7'h00);
        // channel messages with running status
        add_row(8'h9F, 1'b1, EV_NONE, LEN_ONE, 8'h9F, 7'h00);
        add_row(8'h3C, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h7F, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h3C, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h00, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h80, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h00, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h40, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'hBA, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h07, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h64, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'hC3, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h7F, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h00, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'hD5, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);
        add_row(8'h40, 1'b0, EV_NONE, LEN_ONE, 8'h00, 7'h00);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].midi, directed_rows[i].fixed, directed_rows[i].want);
        end

        while (bytes_sent < 445) begin
            plan_burst();
            while (midi_stream.size() != 0) begin
                send_byte(midi_stream.pop_front(), 1'b0, '0);
            end
            if (!paused && bytes_sent >= 220) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_msgs.size() != 0) @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/mbsp_pkg.sv
design/mbsp_decode.sv
design/mbsp_out_reg.sv
design/midi_byte_stream_parser.sv
tb/sv/midi_byte_stream_parser_test.sv
